### sv/atr_pkg.sv
`default_nettype none

package atr_pkg;

  localparam int PRICE_WIDTH  = 32;
  localparam int WINDOW_WIDTH = 16;
  localparam int WINDOW_RESET = 14;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  localparam logic [APB_ADDR_WIDTH-3:0] REG_WINDOW_LENGTH = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### sv/average_true_range_filter.sv
// Requests are handled one at a time: a new request is taken only after the previous result
// has been loaded into the output register. Every average is computed by the shared
// restoring divider, which retires one quotient bit per cycle.
// A new request is taken while a finished result still waits in the output register.
// Reset is synchronous and active high; it clears the series state and sets the window to 14.
`default_nettype none

module average_true_range_filter #(
  parameter int PRICE_WIDTH  = atr_pkg::PRICE_WIDTH,
  parameter int WINDOW_WIDTH = atr_pkg::WINDOW_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 series_start,
  input  wire  [PRICE_WIDTH-1:0]              high_price,
  input  wire  [PRICE_WIDTH-1:0]              low_price,
  input  wire  [PRICE_WIDTH-1:0]              close_price,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [PRICE_WIDTH-1:0]              atr_value,
  output logic                                in_warm_up,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [atr_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  wire  [atr_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [atr_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  localparam int SUM_WIDTH = PRICE_WIDTH + WINDOW_WIDTH;
  localparam int CNT_WIDTH = $clog2(SUM_WIDTH + 1);

  atr_pkg::state_t state, state_next;

  logic [WINDOW_WIDTH-1:0] window_length;
  logic [PRICE_WIDTH-1:0]  previous_close;
  logic [PRICE_WIDTH-1:0]  previous_average;
  logic [SUM_WIDTH-1:0]    range_sum;
  logic [WINDOW_WIDTH-1:0] bars_seen;

  logic [PRICE_WIDTH-1:0]  bar_high;
  logic [PRICE_WIDTH-1:0]  bar_low;
  logic [PRICE_WIDTH-1:0]  bar_close;
  logic [PRICE_WIDTH-1:0]  bar_range;
  logic [SUM_WIDTH-1:0]    product;
  logic                    warm;

  logic [SUM_WIDTH-1:0]    quotient;
  logic [WINDOW_WIDTH-1:0] remainder;
  logic [WINDOW_WIDTH-1:0] divisor;
  logic [CNT_WIDTH-1:0]    div_count;

  logic                    accept;
  logic                    cfg_write;
  logic                    div_last;
  logic                    load_output;
  logic [WINDOW_WIDTH-1:0] window_eff;
  logic [WINDOW_WIDTH-1:0] window_less_one;
  logic [PRICE_WIDTH-1:0]  gap_hl;
  logic [PRICE_WIDTH-1:0]  gap_hc;
  logic [PRICE_WIDTH-1:0]  gap_lc;
  logic [PRICE_WIDTH-1:0]  bar_range_next;
  logic [WINDOW_WIDTH:0]   trial;
  logic                    trial_fits;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[atr_pkg::APB_ADDR_WIDTH-1:2] == atr_pkg::REG_WINDOW_LENGTH);

  always_comb begin
    prdata = '0;
    if (paddr[atr_pkg::APB_ADDR_WIDTH-1:2] == atr_pkg::REG_WINDOW_LENGTH) begin
      prdata[WINDOW_WIDTH-1:0] = window_length;
    end
  end

  assign window_eff      = (window_length == '0) ? WINDOW_WIDTH'(1) : window_length;
  assign window_less_one = window_eff - WINDOW_WIDTH'(1);

  always_comb begin
    gap_hl = (bar_high >= bar_low) ? bar_high - bar_low : bar_low - bar_high;
    gap_hc = (bar_high >= previous_close) ? bar_high - previous_close
                                          : previous_close - bar_high;
    gap_lc = (bar_low >= previous_close) ? bar_low - previous_close
                                         : previous_close - bar_low;
    bar_range_next = gap_hl;
    if (bars_seen != '0) begin
      if (gap_hc > bar_range_next) begin
        bar_range_next = gap_hc;
      end
      if (gap_lc > bar_range_next) begin
        bar_range_next = gap_lc;
      end
    end
  end

  assign trial      = {remainder, quotient[SUM_WIDTH-1]};
  assign trial_fits = (trial >= {1'b0, divisor});
  assign div_last   = (div_count == CNT_WIDTH'(SUM_WIDTH - 1));

  always_comb begin
    state_next = state;
    case (state)
      atr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = atr_pkg::ST_RANGE;
        end
      end
      atr_pkg::ST_RANGE:  state_next = atr_pkg::ST_PREP;
      atr_pkg::ST_PREP:   state_next = atr_pkg::ST_DIVIDE;
      atr_pkg::ST_DIVIDE: begin
        if (div_last) begin
          state_next = atr_pkg::ST_DONE;
        end
      end
      atr_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = atr_pkg::ST_IDLE;
        end
      end
      default: state_next = atr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    load_output = 1'b0;
    case (state)
      atr_pkg::ST_IDLE: in_ready    = 1'b1;
      atr_pkg::ST_DONE: load_output = !out_valid || out_ready;
      default: begin
        in_ready    = 1'b0;
        load_output = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= atr_pkg::ST_IDLE;
      window_length    <= WINDOW_WIDTH'(atr_pkg::WINDOW_RESET);
      previous_close   <= '0;
      previous_average <= '0;
      range_sum        <= '0;
      bars_seen        <= '0;
      out_valid        <= 1'b0;
      div_count        <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        window_length <= pwdata[WINDOW_WIDTH-1:0];
      end
      if (accept && series_start) begin
        bars_seen <= '0;
        range_sum <= '0;
      end
      if (state == atr_pkg::ST_PREP) begin
        previous_close <= bar_close;
        div_count      <= '0;
        if (warm) begin
          range_sum <= range_sum + SUM_WIDTH'(bar_range);
          bars_seen <= bars_seen + WINDOW_WIDTH'(1);
        end else begin
          bars_seen <= window_eff;
        end
      end
      if (state == atr_pkg::ST_DIVIDE) begin
        div_count <= div_count + CNT_WIDTH'(1);
      end
      if (load_output) begin
        previous_average <= quotient[PRICE_WIDTH-1:0];
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bar_high  <= high_price;
      bar_low   <= low_price;
      bar_close <= close_price;
    end
    if (state == atr_pkg::ST_RANGE) begin
      bar_range <= bar_range_next;
      warm      <= (bars_seen < window_eff);
      product   <= {{WINDOW_WIDTH{1'b0}}, previous_average} *
                   {{PRICE_WIDTH{1'b0}}, window_less_one};
    end
    if (state == atr_pkg::ST_PREP) begin
      remainder <= '0;
      if (warm) begin
        quotient <= range_sum + SUM_WIDTH'(bar_range);
        divisor  <= bars_seen + WINDOW_WIDTH'(1);
      end else begin
        quotient <= product + SUM_WIDTH'(bar_range);
        divisor  <= window_eff;
      end
    end
    if (state == atr_pkg::ST_DIVIDE) begin
      remainder <= trial_fits ? WINDOW_WIDTH'(trial - {1'b0, divisor})
                              : trial[WINDOW_WIDTH-1:0];
      quotient  <= {quotient[SUM_WIDTH-2:0], trial_fits};
    end
    if (load_output) begin
      atr_value  <= quotient[PRICE_WIDTH-1:0];
      in_warm_up <= warm;
    end
  end

endmodule

`default_nettype wire

### sv/atr_checker.sv
`default_nettype none

module atr_checker #(
  parameter int PRICE_WIDTH = atr_pkg::PRICE_WIDTH
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [PRICE_WIDTH-1:0] atr_value,
  input wire                   in_warm_up
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(atr_value) && $stable(in_warm_up))
    else $error("result changed or dropped while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is still in work");

  // Reset leaves no result pending and the block free for a request.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty and free after reset");

  // The result is published as the block becomes free again.
  a_free_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the block is still busy");

endmodule

bind average_true_range_filter atr_checker #(
  .PRICE_WIDTH(PRICE_WIDTH)
) u_atr_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .atr_value(atr_value),
  .in_warm_up(in_warm_up)
);

`default_nettype wire

### bench/average_true_range_filter_tb.sv
`timescale 1ns / 100ps

module average_true_range_filter_tb;

  localparam int PRICE_WIDTH    = atr_pkg::PRICE_WIDTH;
  localparam int WINDOW_WIDTH   = atr_pkg::WINDOW_WIDTH;
  localparam int WINDOW_RESET   = atr_pkg::WINDOW_RESET;
  localparam int APB_ADDR_WIDTH = atr_pkg::APB_ADDR_WIDTH;
  localparam int APB_DATA_WIDTH = atr_pkg::APB_DATA_WIDTH;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 400;
  localparam int PHASES       = 10;
  localparam int PHASE_BARS   = 125;

  typedef struct packed {
    logic                   series_start;
    logic [PRICE_WIDTH-1:0] high_price;
    logic [PRICE_WIDTH-1:0] low_price;
    logic [PRICE_WIDTH-1:0] close_price;
  } bar_t;

  typedef struct packed {
    logic [PRICE_WIDTH-1:0] atr_value;
    logic                   in_warm_up;
  } atr_t;

  logic                      clk;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic                      series_start = 1'b0;
  logic [PRICE_WIDTH-1:0]    high_price   = '0;
  logic [PRICE_WIDTH-1:0]    low_price    = '0;
  logic [PRICE_WIDTH-1:0]    close_price  = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [PRICE_WIDTH-1:0]    atr_value;
  logic                      in_warm_up;
  logic                      psel         = 1'b0;
  logic                      penable      = 1'b0;
  logic                      pwrite       = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr        = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata       = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  bar_t bar_queue[$];
  atr_t atr_expected[$];
  bar_t bar_on_port;

  logic [WINDOW_WIDTH-1:0]             window_len = WINDOW_WIDTH'(WINDOW_RESET);
  logic [PRICE_WIDTH-1:0]              prior_close = '0;
  logic [PRICE_WIDTH-1:0]              prior_atr = '0;
  logic [PRICE_WIDTH+WINDOW_WIDTH-1:0] tr_sum = '0;
  logic [WINDOW_WIDTH-1:0]             bars_in_series = '0;

  logic [PRICE_WIDTH-1:0] price_level = '0;
  int   series_left = 0;
  bit   quiet_run = 1'b0;
  int   hold_request = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   mismatch_count = 0;

  average_true_range_filter u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .series_start (series_start),
    .high_price   (high_price),
    .low_price    (low_price),
    .close_price  (close_price),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .atr_value    (atr_value),
    .in_warm_up   (in_warm_up),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [PRICE_WIDTH-1:0] price_gap(input logic [PRICE_WIDTH-1:0] a,
                                                       input logic [PRICE_WIDTH-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [PRICE_WIDTH-1:0] sat_up(input logic [PRICE_WIDTH-1:0] a,
                                                    input logic [PRICE_WIDTH-1:0] d);
    logic [PRICE_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[PRICE_WIDTH] ? {PRICE_WIDTH{1'b1}} : s[PRICE_WIDTH-1:0];
  endfunction

  function automatic logic [PRICE_WIDTH-1:0] sat_down(input logic [PRICE_WIDTH-1:0] a,
                                                      input logic [PRICE_WIDTH-1:0] d);
    return (a > d) ? a - d : '0;
  endfunction

  task automatic advance_atr(input bar_t b);
    logic [PRICE_WIDTH-1:0]  tr;
    logic [WINDOW_WIDTH:0]   n;
    logic [63:0]             quotient;
    atr_t                    r;
    n = (window_len == '0) ? (WINDOW_WIDTH+1)'(1) : {1'b0, window_len};
    if (b.series_start) begin
      bars_in_series = '0;
      tr_sum = '0;
    end
    tr = price_gap(b.high_price, b.low_price);
    if (bars_in_series != '0) begin
      if (price_gap(b.high_price, prior_close) > tr) tr = price_gap(b.high_price, prior_close);
      if (price_gap(b.low_price, prior_close) > tr) tr = price_gap(b.low_price, prior_close);
    end
    if ({1'b0, bars_in_series} < n) begin
      r.in_warm_up = 1'b1;
      tr_sum = tr_sum + tr;
      quotient = 64'(tr_sum) / (64'(bars_in_series) + 64'd1);
      bars_in_series = bars_in_series + 1'b1;
    end else begin
      r.in_warm_up = 1'b0;
      quotient = (64'(prior_atr) * (64'(n) - 64'd1) + 64'(tr)) / 64'(n);
      bars_in_series = n[WINDOW_WIDTH-1:0];
    end
    r.atr_value = quotient[PRICE_WIDTH-1:0];
    prior_atr = r.atr_value;
    prior_close = b.close_price;
    atr_expected.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
  endtask

  task automatic push_bar(input logic ss, input logic [PRICE_WIDTH-1:0] hi,
                          input logic [PRICE_WIDTH-1:0] lo, input logic [PRICE_WIDTH-1:0] cl);
    bar_t b;
    b.series_start = ss;
    b.high_price = hi;
    b.low_price = lo;
    b.close_price = cl;
    bar_queue.push_back(b);
  endtask

  task automatic queue_random_bars(input int count);
    bar_t                   b;
    logic [PRICE_WIDTH-1:0] spread_mask;
    int                     lim;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        b.series_start = 1'($urandom_range(0, 1));
        b.high_price = PRICE_WIDTH'($urandom);
        b.low_price = PRICE_WIDTH'($urandom);
        b.close_price = PRICE_WIDTH'($urandom);
        price_level = b.close_price;
      end else begin
        spread_mask = {PRICE_WIDTH{1'b1}} >> $urandom_range(0, PRICE_WIDTH - 1);
        b.series_start = (series_left == 0);
        if (series_left == 0) begin
          lim = (window_len == '0) ? 1 : int'(window_len);
          lim = (3 * lim + 4 > 60) ? 60 : 3 * lim + 4;
          series_left = $urandom_range(1, lim);
        end
        series_left--;
        if ($urandom_range(0, 1) == 1) price_level = sat_up(price_level, $urandom & spread_mask);
        else price_level = sat_down(price_level, $urandom & spread_mask);
        b.high_price = sat_up(price_level, $urandom & spread_mask);
        b.low_price = sat_down(price_level, $urandom & spread_mask);
        b.close_price = price_level;
      end
      bar_queue.push_back(b);
    end
  endtask

  task automatic write_window(input logic [WINDOW_WIDTH-1:0] value);
    logic [APB_DATA_WIDTH-1:0] word;
    word = APB_DATA_WIDTH'($urandom);
    word[WINDOW_WIDTH-1:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {atr_pkg::REG_WINDOW_LENGTH, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    window_len = value;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bar_queue.size() != 0 || in_valid || atr_expected.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_atr(bar_on_port);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bar_queue.size() != 0) begin
          bar_on_port = bar_queue.pop_front();
          series_start <= bar_on_port.series_start;
          high_price <= bar_on_port.high_price;
          low_price <= bar_on_port.low_price;
          close_price <= bar_on_port.close_price;
          in_valid <= 1'b1;
          send_gap = quiet_run ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    atr_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (atr_expected.size() == 0) begin
          report_mismatch("unexpected result", 64'({atr_value, in_warm_up}), 64'd0);
        end else begin
          want = atr_expected.pop_front();
          if (atr_value !== want.atr_value)
            report_mismatch("atr_value", 64'(atr_value), 64'(want.atr_value));
          if (in_warm_up !== want.in_warm_up)
            report_mismatch("in_warm_up", 64'(in_warm_up), 64'(want.in_warm_up));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left = hold_request - 1;
        hold_request = 0;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_run && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("average_true_range_filter_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [WINDOW_WIDTH-1:0] next_window;
    int                      pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first bar after reset carries no series start.
    push_bar(1'b0, 32'h0005_0000, 32'h0003_0000, 32'h0004_0000);
    push_bar(1'b0, 32'h0006_0000, 32'h0005_8000, 32'h0005_9000);
    push_bar(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    push_bar(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    push_bar(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    push_bar(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    push_bar(1'b0, 32'h0001_8000, 32'h0000_8000, 32'h0001_2345);
    push_bar(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
    push_bar(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE);
    wait_drained();

    write_window(16'd1);
    push_bar(1'b1, 32'h0010_0000, 32'h0008_0000, 32'h000C_0000);
    push_bar(1'b0, 32'h0020_0000, 32'h0018_0000, 32'h001C_0000);
    wait_drained();

    // A window of zero behaves as a window of one.
    write_window(16'd0);
    push_bar(1'b1, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
    push_bar(1'b0, 32'h0009_0000, 32'h0008_0000, 32'h0008_8000);
    push_bar(1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    wait_drained();

    // Window changes in the middle of a series.
    write_window(16'd3);
    push_bar(1'b0, 32'h0004_0000, 32'h0002_0000, 32'h0003_0000);
    push_bar(1'b0, 32'h0007_0000, 32'h0003_0000, 32'h0006_0000);
    push_bar(1'b0, 32'h0006_8000, 32'h0006_0000, 32'h0006_4000);
    wait_drained();
    write_window(16'hFFFF);
    push_bar(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    push_bar(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    wait_drained();
    write_window(16'd2);
    push_bar(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_bar(1'b0, 32'h0100_0000, 32'h00F0_0000, 32'h00F8_0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      pick = $urandom_range(0, 7);
      case (pick)
        0: next_window = '0;
        1: next_window = '1;
        2: next_window = WINDOW_WIDTH'($urandom);
        default: next_window = WINDOW_WIDTH'($urandom_range(1, 20));
      endcase
      write_window(next_window);
      quiet_run = (ph == 2);
      if (ph == 5) hold_request = LONG_HOLD;
      queue_random_bars(PHASE_BARS);
    end

    wait_drained();
    write_window(WINDOW_WIDTH'(WINDOW_RESET));
    quiet_run = 1'b0;
    queue_random_bars(30);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && atr_expected.size() == 0) begin
      $display("average_true_range_filter_tb OK");
    end else begin
      $display("average_true_range_filter_tb NOT OK");
    end
    $finish;
  end

endmodule
